// ===== hdl/cdm_pkg.sv =====
// Cup-drop motor controller: shared types and constants.
// No dependencies; cdm_step.sv and the core file import this package, cdm_if.sv does not.
package cdm_pkg;

  // Request command codes
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_ABORT = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_AWAY    = 2'd0,
    REG_BACK    = 2'd1,
    REG_RELEASE = 2'd2,
    REG_TIMEOUT = 2'd3
  } reg_idx_e;

  localparam int unsigned CfgDataW = 16;

  localparam logic [7:0]  AwayReset    = 8'd50;
  localparam logic [7:0]  BackReset    = 8'd10;
  localparam logic [7:0]  ReleaseReset = 8'd30;
  localparam logic [15:0] TimeoutReset = 16'd800;

  localparam logic [15:0] RunTimerMax = 16'hFFFF;

  typedef struct packed {
    logic [7:0]  away_ticks;
    logic [7:0]  back_ticks;
    logic [7:0]  release_ticks;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic        active;
    logic        drop_ok;
    logic        left_rest;
    logic        returned;
    logic [15:0] run_timer;
    logic [8:0]  leave_count;
    logic [7:0]  return_count;
    logic [7:0]  release_count;
  } state_t;

  typedef struct packed {
    logic motor_on;
    logic busy_res;
    logic finished;
    logic success;
  } res_t;

endpackage

// ===== hdl/cdm_if.sv =====
// Cup-drop motor controller: request and result stream interfaces.
// Valid/ready handshake; depends on no package.
interface cdm_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic       switch_level;

  modport source (output valid, command, switch_level, input ready);
  modport sink   (input valid, command, switch_level, output ready);
endinterface

interface cdm_res_if;
  logic valid;
  logic ready;
  logic motor_on;
  logic busy_res;
  logic finished;
  logic success;

  modport source (output valid, motor_on, busy_res, finished, success, input ready);
  modport sink   (input valid, motor_on, busy_res, finished, success, output ready);
endinterface

// ===== hdl/cdm_step.sv =====
// Cup-drop motor controller: next-state and result logic for one request.
// Purely combinational; uses cdm_pkg.
module cdm_step import cdm_pkg::*; (
  input  cfg_t       cfg_i,
  input  state_t     state_i,
  input  logic [1:0] command_i,
  input  logic       switch_level_i,
  output state_t     state_o,
  output res_t       res_o
);

  state_t s;
  logic   fin;
  cmd_e   cmd;

  assign cmd = cmd_e'(command_i);

  always_comb begin
    s   = state_i;
    fin = 1'b0;
    case (cmd)
      CMD_START: begin
        s.active  = 1'b1;
        s.drop_ok = 1'b0;
      end
      CMD_ABORT: begin
        s.active = 1'b0;
      end
      CMD_TICK: begin
        if (state_i.active) begin
          // run timer, saturating
          if (s.run_timer != RunTimerMax) s.run_timer = s.run_timer + 16'd1;

          // debounce switch leaving rest
          if (!switch_level_i) begin
            if (s.leave_count > {1'b0, cfg_i.away_ticks}) s.left_rest = 1'b1;
            else s.leave_count = s.leave_count + 9'd1;
          end else begin
            s.leave_count = '0;
          end

          // debounce return; release delay starts on first confirmed return
          if (s.left_rest) begin
            if (switch_level_i) begin
              if (s.return_count < cfg_i.back_ticks) s.return_count = s.return_count + 8'd1;
              if (s.return_count >= cfg_i.back_ticks && !s.returned) begin
                s.returned      = 1'b1;
                s.release_count = '0;
              end
            end else begin
              s.return_count = '0;
            end
          end

          // release delay
          if (s.returned) begin
            if (s.release_count >= cfg_i.release_ticks) begin
              s.active  = 1'b0;
              s.drop_ok = 1'b1;
              fin       = 1'b1;
            end else begin
              s.release_count = s.release_count + 8'd1;
            end
          end

          // timeout takes precedence
          if (s.run_timer >= cfg_i.timeout_ticks) begin
            s.active  = 1'b0;
            s.drop_ok = 1'b0;
            fin       = 1'b1;
          end
        end else begin
          s.run_timer     = '0;
          s.release_count = '0;
          s.left_rest     = 1'b0;
          s.returned      = 1'b0;
        end
      end
      default: begin
        // unused code: no state change
      end
    endcase
  end

  assign state_o        = s;
  assign res_o.motor_on = s.active;
  assign res_o.busy_res = s.active;
  assign res_o.finished = fin;
  assign res_o.success  = s.drop_ok;

endmodule

// ===== hdl/cup_drop_motor_controller_core.sv =====
// Cup-drop motor controller top level: request register, step logic, result register.
// Uses cdm_pkg, cdm_req_if, cdm_res_if and cdm_step.

// One request per clock cycle, sustained while results are taken. A request
// is taken into an input register, then runs through the step logic, which
// updates the controller state and loads the result register at the same
// edge, once the result register is empty or being read. The request side
// stays ready while a result is waiting, as long as the input register is
// empty or can move on; results keep request order, one result per request.
// Configuration writes should only be made while no request is in flight.
module cup_drop_motor_controller_core import cdm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  cdm_req_if.sink             req_i,
  cdm_res_if.source           res_o
);

  cfg_t       cfg_q;
  state_t     state_q, state_d;
  res_t       res_d, res_q;
  logic       in_vld_q, out_vld_q;
  logic [1:0] cmd_q;
  logic       sw_q;
  logic       advance;
  logic       in_take;

  // Handshake control
  assign advance     = in_vld_q && (!out_vld_q || res_o.ready);
  assign req_i.ready = !in_vld_q || advance;
  assign in_take     = req_i.valid && req_i.ready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.away_ticks    <= AwayReset;
      cfg_q.back_ticks    <= BackReset;
      cfg_q.release_ticks <= ReleaseReset;
      cfg_q.timeout_ticks <= TimeoutReset;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_AWAY:    cfg_q.away_ticks    <= cfg_data_i[7:0];
        REG_BACK:    cfg_q.back_ticks    <= cfg_data_i[7:0];
        REG_RELEASE: cfg_q.release_ticks <= cfg_data_i[7:0];
        REG_TIMEOUT: cfg_q.timeout_ticks <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      in_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q <= req_i.command;
      sw_q  <= req_i.switch_level;
    end
  end

  // Step logic
  cdm_step u_step (
    .cfg_i          (cfg_q),
    .state_i        (state_q),
    .command_i      (cmd_q),
    .switch_level_i (sw_q),
    .state_o        (state_d),
    .res_o          (res_d)
  );

  // Controller state, updated once per request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) res_q <= res_d;
  end

  assign res_o.valid    = out_vld_q;
  assign res_o.motor_on = res_q.motor_on;
  assign res_o.busy_res = res_q.busy_res;
  assign res_o.finished = res_q.finished;
  assign res_o.success  = res_q.success;

  // Assertions
  a_returned_needs_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.returned |-> state_q.left_rest)
    else $error("return confirmed without departure");

  a_finish_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.finished) |-> !res_q.busy_res)
    else $error("finished pulse while cycle still busy");

  a_advance_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("processed request did not produce a result");

endmodule
